[rtl/cpro_pkg.sv]
// ----------------------------------------------------------------------------
// cpro_pkg
// Shared types and constants for the clipped pixel raster-op unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cpro_pkg;

    localparam int REG_W   = 13;
    localparam int MODE_W  = 3;
    localparam int PIXEL_W = 32;
    localparam int IDX_W   = 3;
    localparam int ARITH_W = 17;

    localparam logic [MODE_W-1:0] MODE_FILL   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BLEND  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INVERT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CHECK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_COPY   = 3'd4;

    localparam logic [IDX_W-1:0] REG_OP_MODE      = 3'd0;
    localparam logic [IDX_W-1:0] REG_FILL_COLOR   = 3'd1;
    localparam logic [IDX_W-1:0] REG_CLIP_LEFT    = 3'd2;
    localparam logic [IDX_W-1:0] REG_CLIP_TOP     = 3'd3;
    localparam logic [IDX_W-1:0] REG_CLIP_WIDTH   = 3'd4;
    localparam logic [IDX_W-1:0] REG_CLIP_HEIGHT  = 3'd5;
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd6;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd7;

    localparam logic [REG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    localparam logic [PIXEL_W-1:0] RGB_MASK   = 32'h00FF_FFFF;
    localparam logic [PIXEL_W-1:0] ALPHA_MASK = 32'hFF00_0000;

    typedef struct packed {
        logic signed [ARITH_W-1:0] x0;
        logic signed [ARITH_W-1:0] y0;
        logic signed [ARITH_W-1:0] x1;
        logic signed [ARITH_W-1:0] y1;
        logic                      nonempty;
    } region_t;

endpackage

`default_nettype wire

[rtl/clipped_pixel_raster_op_top.sv]
// An accepted request is captured in the input register, and its result then in
// the result register, where it stays valid until taken. Throughput: one pixel
// per cycle, limited only by output stall. Stall propagates combinationally from
// the output to the input.
// Reset: asynchronous active low; clears valid flags and the mode, fill and clip
// configuration registers, and sets the frame size to 640x480.
// ----------------------------------------------------------------------------
// clipped_pixel_raster_op_top
// Per-pixel raster-op unit with clip rectangle and five drawing modes.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_pixel_raster_op_top #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [cpro_pkg::IDX_W-1:0]        cfg_index,
    input  wire logic [cpro_pkg::PIXEL_W-1:0]      cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [COORD_BITS-1:0]             pix_col,
    input  wire logic [COORD_BITS-1:0]             pix_row,
    input  wire logic [cpro_pkg::PIXEL_W-1:0]      dest_pixel,
    input  wire logic [cpro_pkg::PIXEL_W-1:0]      source_pixel,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [cpro_pkg::PIXEL_W-1:0]      result_pixel,
    output logic                                   pixel_changed
);

    logic [cpro_pkg::MODE_W-1:0]  op_mode_reg;
    logic [cpro_pkg::PIXEL_W-1:0] fill_color_reg;
    logic [cpro_pkg::REG_W-1:0]   clip_left_reg;
    logic [cpro_pkg::REG_W-1:0]   clip_top_reg;
    logic [cpro_pkg::REG_W-1:0]   clip_width_reg;
    logic [cpro_pkg::REG_W-1:0]   clip_height_reg;
    logic [cpro_pkg::REG_W-1:0]   frame_width_reg;
    logic [cpro_pkg::REG_W-1:0]   frame_height_reg;

    logic                         s1_valid_reg;
    logic [COORD_BITS-1:0]        s1_col_reg;
    logic [COORD_BITS-1:0]        s1_row_reg;
    logic [cpro_pkg::PIXEL_W-1:0] s1_dest_reg;
    logic [cpro_pkg::PIXEL_W-1:0] s1_src_reg;

    logic                         out_valid_reg;
    logic [cpro_pkg::PIXEL_W-1:0] result_pixel_reg;
    logic                         pixel_changed_reg;

    logic                         advance;
    cpro_pkg::region_t            region;
    logic [cpro_pkg::PIXEL_W-1:0] result_next;
    logic                         changed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg      <= cpro_pkg::MODE_FILL;
            fill_color_reg   <= '0;
            clip_left_reg    <= '0;
            clip_top_reg     <= '0;
            clip_width_reg   <= '0;
            clip_height_reg  <= '0;
            frame_width_reg  <= cpro_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= cpro_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cpro_pkg::REG_OP_MODE:      op_mode_reg      <= cfg_data[cpro_pkg::MODE_W-1:0];
                cpro_pkg::REG_FILL_COLOR:   fill_color_reg   <= cfg_data;
                cpro_pkg::REG_CLIP_LEFT:    clip_left_reg    <= cfg_data[cpro_pkg::REG_W-1:0];
                cpro_pkg::REG_CLIP_TOP:     clip_top_reg     <= cfg_data[cpro_pkg::REG_W-1:0];
                cpro_pkg::REG_CLIP_WIDTH:   clip_width_reg   <= cfg_data[cpro_pkg::REG_W-1:0];
                cpro_pkg::REG_CLIP_HEIGHT:  clip_height_reg  <= cfg_data[cpro_pkg::REG_W-1:0];
                cpro_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[cpro_pkg::REG_W-1:0];
                cpro_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[cpro_pkg::REG_W-1:0];
                default:                    op_mode_reg      <= op_mode_reg;
            endcase
        end
    end

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_col_reg  <= pix_col;
            s1_row_reg  <= pix_row;
            s1_dest_reg <= dest_pixel;
            s1_src_reg  <= source_pixel;
        end
        if (s1_valid_reg && advance)
        begin
            result_pixel_reg  <= result_next;
            pixel_changed_reg <= changed_next;
        end
    end

    cpro_region u_region (
        .clip_left    ($signed(clip_left_reg)),
        .clip_top     ($signed(clip_top_reg)),
        .clip_width   (clip_width_reg),
        .clip_height  (clip_height_reg),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .region       (region)
    );

    cpro_pixel_op #(
        .COORD_BITS (COORD_BITS)
    ) u_pixel_op (
        .op_mode       (op_mode_reg),
        .fill_color    (fill_color_reg),
        .region        (region),
        .pix_col       (s1_col_reg),
        .pix_row       (s1_row_reg),
        .dest_pixel    (s1_dest_reg),
        .source_pixel  (s1_src_reg),
        .result_pixel  (result_next),
        .pixel_changed (changed_next)
    );

    assign out_valid     = out_valid_reg;
    assign result_pixel  = result_pixel_reg;
    assign pixel_changed = pixel_changed_reg;

endmodule

`default_nettype wire

[rtl/cpro_region.sv]
// ----------------------------------------------------------------------------
// cpro_region
// Intersects the clip rectangle with the framebuffer bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module cpro_region (
    input  wire logic signed [cpro_pkg::REG_W-1:0] clip_left,
    input  wire logic signed [cpro_pkg::REG_W-1:0] clip_top,
    input  wire logic        [cpro_pkg::REG_W-1:0] clip_width,
    input  wire logic        [cpro_pkg::REG_W-1:0] clip_height,
    input  wire logic        [cpro_pkg::REG_W-1:0] frame_width,
    input  wire logic        [cpro_pkg::REG_W-1:0] frame_height,
    output cpro_pkg::region_t                      region
);

    localparam int EXT_W = cpro_pkg::ARITH_W - cpro_pkg::REG_W;

    logic signed [cpro_pkg::ARITH_W-1:0] left_s;
    logic signed [cpro_pkg::ARITH_W-1:0] top_s;
    logic signed [cpro_pkg::ARITH_W-1:0] cw_s;
    logic signed [cpro_pkg::ARITH_W-1:0] ch_s;
    logic signed [cpro_pkg::ARITH_W-1:0] fw_s;
    logic signed [cpro_pkg::ARITH_W-1:0] fh_s;
    logic signed [cpro_pkg::ARITH_W-1:0] right_raw;
    logic signed [cpro_pkg::ARITH_W-1:0] bottom_raw;

    always_comb
    begin
        left_s     = $signed({{EXT_W{clip_left[cpro_pkg::REG_W-1]}}, clip_left});
        top_s      = $signed({{EXT_W{clip_top[cpro_pkg::REG_W-1]}}, clip_top});
        cw_s       = $signed({{EXT_W{1'b0}}, clip_width});
        ch_s       = $signed({{EXT_W{1'b0}}, clip_height});
        fw_s       = $signed({{EXT_W{1'b0}}, frame_width});
        fh_s       = $signed({{EXT_W{1'b0}}, frame_height});
        right_raw  = left_s + cw_s;
        bottom_raw = top_s + ch_s;

        region.x0 = (left_s > 0) ? left_s : '0;
        region.y0 = (top_s > 0) ? top_s : '0;
        region.x1 = (right_raw > fw_s) ? fw_s : right_raw;
        region.y1 = (bottom_raw > fh_s) ? fh_s : bottom_raw;
        region.nonempty = (region.x1 > region.x0) && (region.y1 > region.y0);
    end

endmodule

`default_nettype wire

[rtl/cpro_pixel_op.sv]
// ----------------------------------------------------------------------------
// cpro_pixel_op
// Region test and per-mode pixel operation for one pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module cpro_pixel_op #(
    parameter int COORD_BITS = 12
) (
    input  wire logic [cpro_pkg::MODE_W-1:0]  op_mode,
    input  wire logic [cpro_pkg::PIXEL_W-1:0] fill_color,
    input  wire cpro_pkg::region_t            region,
    input  wire logic [COORD_BITS-1:0]        pix_col,
    input  wire logic [COORD_BITS-1:0]        pix_row,
    input  wire logic [cpro_pkg::PIXEL_W-1:0] dest_pixel,
    input  wire logic [cpro_pkg::PIXEL_W-1:0] source_pixel,
    output logic      [cpro_pkg::PIXEL_W-1:0] result_pixel,
    output logic                              pixel_changed
);

    localparam int EXT_W = cpro_pkg::ARITH_W - COORD_BITS;

    function automatic logic [7:0] blend_chan(
        input logic [7:0] a,
        input logic [7:0] fg,
        input logic [7:0] d
    );
        logic [8:0]  wa;
        logic [8:0]  wd;
        logic [15:0] sum;
        wa  = {1'b0, a} + 9'd1;
        wd  = 9'd256 - {1'b0, a};
        sum = wa * {1'b0, fg} + wd * {1'b0, d};
        return sum[15:8];
    endfunction

    logic signed [cpro_pkg::ARITH_W-1:0] col_s;
    logic signed [cpro_pkg::ARITH_W-1:0] row_s;
    logic                                in_region;
    logic                                even;
    logic [7:0]                          alpha;
    logic [cpro_pkg::PIXEL_W-1:0]        blended;

    always_comb
    begin
        col_s  = $signed({{EXT_W{1'b0}}, pix_col});
        row_s  = $signed({{EXT_W{1'b0}}, pix_row});
        in_region = region.nonempty && (col_s >= region.x0) && (col_s < region.x1)
                    && (row_s >= region.y0) && (row_s < region.y1);
        even   = ~(pix_col[0] ^ pix_row[0] ^ region.x0[0] ^ region.y0[0]);
        alpha  = fill_color[31:24];

        blended = {blend_chan(alpha, alpha, dest_pixel[31:24]),
                   blend_chan(alpha, fill_color[23:16], dest_pixel[23:16]),
                   blend_chan(alpha, fill_color[15:8], dest_pixel[15:8]),
                   blend_chan(alpha, fill_color[7:0], dest_pixel[7:0])};

        result_pixel  = dest_pixel;
        pixel_changed = 1'b0;
        if (in_region)
        begin
            unique case (op_mode)
                cpro_pkg::MODE_FILL:
                begin
                    result_pixel  = fill_color;
                    pixel_changed = 1'b1;
                end
                cpro_pkg::MODE_BLEND:
                begin
                    result_pixel  = blended;
                    pixel_changed = 1'b1;
                end
                cpro_pkg::MODE_INVERT:
                begin
                    result_pixel  = dest_pixel ^ cpro_pkg::RGB_MASK;
                    pixel_changed = 1'b1;
                end
                cpro_pkg::MODE_CHECK:
                begin
                    if (even)
                    begin
                        result_pixel  = dest_pixel ^ cpro_pkg::RGB_MASK;
                        pixel_changed = 1'b1;
                    end
                end
                cpro_pkg::MODE_COPY:
                begin
                    result_pixel  = source_pixel | cpro_pkg::ALPHA_MASK;
                    pixel_changed = 1'b1;
                end
                default:
                begin
                    result_pixel  = dest_pixel;
                    pixel_changed = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[test/raster_op_checker.sv]
// ----------------------------------------------------------------------------
// raster_op_checker
// Tracks register writes, predicts each accepted pixel request against the
// clipped region and current drawing mode, and compares every accepted result
// field by field with the oldest prediction. Reports a failure count and the
// number of results still owed.
// ----------------------------------------------------------------------------
module raster_op_checker #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [cpro_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [cpro_pkg::PIXEL_W-1:0]  cfg_data,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic [COORD_BITS-1:0]         pix_col,
    input  wire logic [COORD_BITS-1:0]         pix_row,
    input  wire logic [cpro_pkg::PIXEL_W-1:0]  dest_pixel,
    input  wire logic [cpro_pkg::PIXEL_W-1:0]  source_pixel,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [cpro_pkg::PIXEL_W-1:0]  result_pixel,
    input  wire logic                          pixel_changed,
    output int                                 errors,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [cpro_pkg::PIXEL_W-1:0] result_pixel;
        logic                         pixel_changed;
    } raster_result_t;

    logic [cpro_pkg::MODE_W-1:0]       mode_q;
    logic [cpro_pkg::PIXEL_W-1:0]      fill_q;
    logic signed [cpro_pkg::REG_W-1:0] clip_left_q;
    logic signed [cpro_pkg::REG_W-1:0] clip_top_q;
    logic [cpro_pkg::REG_W-1:0]        clip_width_q;
    logic [cpro_pkg::REG_W-1:0]        clip_height_q;
    logic [cpro_pkg::REG_W-1:0]        frame_width_q;
    logic [cpro_pkg::REG_W-1:0]        frame_height_q;

    raster_result_t expected_pixels[$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    function automatic logic [7:0] blend_channel(input logic [7:0] alpha,
                                                 input logic [7:0] fg,
                                                 input logic [7:0] dst);
        int unsigned a;
        int unsigned sum;
        a   = alpha;
        sum = (a + 1) * fg + (256 - a) * dst;
        return 8'(sum >> 8);
    endfunction

    function automatic raster_result_t predict_raster(
        input logic [COORD_BITS-1:0]       col,
        input logic [COORD_BITS-1:0]       row,
        input logic [cpro_pkg::PIXEL_W-1:0] dst,
        input logic [cpro_pkg::PIXEL_W-1:0] src);
        int             left;
        int             top;
        int             x0;
        int             y0;
        int             x1;
        int             y1;
        int             c;
        int             r;
        logic           in_region;
        logic [7:0]     alpha;
        raster_result_t res;
        left  = clip_left_q;
        top   = clip_top_q;
        c     = int'(col);
        r     = int'(row);
        x0    = (left > 0) ? left : 0;
        y0    = (top > 0) ? top : 0;
        x1    = left + int'(clip_width_q);
        y1    = top + int'(clip_height_q);
        if (x1 > int'(frame_width_q))
            x1 = int'(frame_width_q);
        if (y1 > int'(frame_height_q))
            y1 = int'(frame_height_q);
        in_region = (x1 > x0) && (y1 > y0) && (c >= x0) && (c < x1) && (r >= y0) && (r < y1);
        alpha  = fill_q[31:24];
        res.result_pixel  = dst;
        res.pixel_changed = 1'b0;
        if (in_region)
        begin
            case (mode_q)
                cpro_pkg::MODE_FILL:
                begin
                    res.result_pixel  = fill_q;
                    res.pixel_changed = 1'b1;
                end
                cpro_pkg::MODE_BLEND:
                begin
                    res.result_pixel  = {blend_channel(alpha, fill_q[31:24], dst[31:24]),
                                         blend_channel(alpha, fill_q[23:16], dst[23:16]),
                                         blend_channel(alpha, fill_q[15:8], dst[15:8]),
                                         blend_channel(alpha, fill_q[7:0], dst[7:0])};
                    res.pixel_changed = 1'b1;
                end
                cpro_pkg::MODE_INVERT:
                begin
                    res.result_pixel  = dst ^ cpro_pkg::RGB_MASK;
                    res.pixel_changed = 1'b1;
                end
                cpro_pkg::MODE_CHECK:
                begin
                    if ((((c - x0) + (r - y0)) & 1) == 0)
                    begin
                        res.result_pixel  = dst ^ cpro_pkg::RGB_MASK;
                        res.pixel_changed = 1'b1;
                    end
                end
                cpro_pkg::MODE_COPY:
                begin
                    res.result_pixel  = src | cpro_pkg::ALPHA_MASK;
                    res.pixel_changed = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        raster_result_t want;
        if (!rst_n)
        begin
            mode_q         = cpro_pkg::MODE_FILL;
            fill_q         = '0;
            clip_left_q    = '0;
            clip_top_q     = '0;
            clip_width_q   = '0;
            clip_height_q  = '0;
            frame_width_q  = cpro_pkg::FRAME_WIDTH_RST;
            frame_height_q = cpro_pkg::FRAME_HEIGHT_RST;
            expected_pixels.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected result: result_pixel %h pixel_changed %b",
                           result_pixel, pixel_changed);
                    errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (result_pixel !== want.result_pixel)
                    begin
                        $error("result_pixel: expected %h, actual %h",
                               want.result_pixel, result_pixel);
                        errors++;
                    end
                    if (pixel_changed !== want.pixel_changed)
                    begin
                        $error("pixel_changed: expected %b, actual %b",
                               want.pixel_changed, pixel_changed);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_pixels.push_back(predict_raster(pix_col, pix_row, dest_pixel,
                                                         source_pixel));
            if (cfg_we)
            begin
                case (cfg_index)
                    cpro_pkg::REG_OP_MODE:
                        mode_q = cfg_data[cpro_pkg::MODE_W-1:0];
                    cpro_pkg::REG_FILL_COLOR:
                        fill_q = cfg_data;
                    cpro_pkg::REG_CLIP_LEFT:
                        clip_left_q = cfg_data[cpro_pkg::REG_W-1:0];
                    cpro_pkg::REG_CLIP_TOP:
                        clip_top_q = cfg_data[cpro_pkg::REG_W-1:0];
                    cpro_pkg::REG_CLIP_WIDTH:
                        clip_width_q = cfg_data[cpro_pkg::REG_W-1:0];
                    cpro_pkg::REG_CLIP_HEIGHT:
                        clip_height_q = cfg_data[cpro_pkg::REG_W-1:0];
                    cpro_pkg::REG_FRAME_WIDTH:
                        frame_width_q = cfg_data[cpro_pkg::REG_W-1:0];
                    cpro_pkg::REG_FRAME_HEIGHT:
                        frame_height_q = cfg_data[cpro_pkg::REG_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            pending = expected_pixels.size();
        end
    end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the clipped pixel raster-op unit: a directed pass over every
// drawing mode and clip edge, then randomized register settings with pixel
// requests aimed around the clipped region, random gaps on both channels and
// one long output hold-off. Checking is done by raster_op_checker.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS = 12;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_AT = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES = 15;
    localparam int PHASE_PIXELS = 50;
    localparam int COORD_MAX = (1 << COORD_BITS) - 1;

    typedef logic [cpro_pkg::MODE_W-1:0] mode_t;
    typedef logic [COORD_BITS-1:0]       coord_t;

    localparam mode_t MODE_RSVD_FIRST = 3'd5;
    localparam mode_t MODE_RSVD_LAST  = 3'd7;
    localparam logic [cpro_pkg::PIXEL_W-1:0] DIRECTED_FILL = 32'h80C0_4020;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [cpro_pkg::IDX_W-1:0]   cfg_index = '0;
    logic [cpro_pkg::PIXEL_W-1:0] cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [COORD_BITS-1:0]        pix_col = '0;
    logic [COORD_BITS-1:0]        pix_row = '0;
    logic [cpro_pkg::PIXEL_W-1:0] dest_pixel = '0;
    logic [cpro_pkg::PIXEL_W-1:0] source_pixel = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [cpro_pkg::PIXEL_W-1:0] result_pixel;
    logic                         pixel_changed;
    int                           errors;
    int                           pending;
    int                           quiet_cycles = 0;
    logic                         calm = 1'b0;

    int          cur_left;
    int          cur_top;
    int          cur_cw;
    int          cur_ch;
    int          cur_fw;
    int          cur_fh;
    logic [31:0] cur_fill;

    clipped_pixel_raster_op_top #(.COORD_BITS(COORD_BITS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pix_col       (pix_col),
        .pix_row       (pix_row),
        .dest_pixel    (dest_pixel),
        .source_pixel  (source_pixel),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_pixel  (result_pixel),
        .pixel_changed (pixel_changed)
    );

    raster_op_checker #(.COORD_BITS(COORD_BITS)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pix_col       (pix_col),
        .pix_row       (pix_row),
        .dest_pixel    (dest_pixel),
        .source_pixel  (source_pixel),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_pixel  (result_pixel),
        .pixel_changed (pixel_changed),
        .errors        (errors),
        .pending       (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[clipped_pixel_raster_op_top] ERROR");
                $finish;
            end
        end
    end

    // result side: random stall per result, one long hold-off to back up the pipe
    initial
    begin
        int taken;
        int wait_cycles;
        taken = 0;
        forever
        begin
            wait_cycles = calm ? 0 : $urandom_range(0, 19);
            if (taken == HOLD_AT)
                wait_cycles = HOLD_CYCLES;
            @(negedge clk);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    task automatic write_reg(input logic [cpro_pkg::IDX_W-1:0] idx, input logic [31:0] value,
                             input int width);
        logic [31:0] noise;
        noise = $urandom() << width;
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= noise | (value & ~(32'hFFFF_FFFF << width));
    endtask

    task automatic apply_settings(input mode_t mode, input logic [31:0] fill,
                                  input int left, input int top, input int cw, input int ch,
                                  input int fw, input int fh);
        write_reg(cpro_pkg::REG_OP_MODE, 32'(mode), cpro_pkg::MODE_W);
        write_reg(cpro_pkg::REG_FILL_COLOR, fill, cpro_pkg::PIXEL_W);
        write_reg(cpro_pkg::REG_CLIP_LEFT, 32'(left), cpro_pkg::REG_W);
        write_reg(cpro_pkg::REG_CLIP_TOP, 32'(top), cpro_pkg::REG_W);
        write_reg(cpro_pkg::REG_CLIP_WIDTH, 32'(cw), cpro_pkg::REG_W);
        write_reg(cpro_pkg::REG_CLIP_HEIGHT, 32'(ch), cpro_pkg::REG_W);
        write_reg(cpro_pkg::REG_FRAME_WIDTH, 32'(fw), cpro_pkg::REG_W);
        write_reg(cpro_pkg::REG_FRAME_HEIGHT, 32'(fh), cpro_pkg::REG_W);
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_left = left;
        cur_top  = top;
        cur_cw   = cw;
        cur_ch   = ch;
        cur_fw   = fw;
        cur_fh   = fh;
        cur_fill = fill;
    endtask

    task automatic send_pixel(input coord_t col, input coord_t row,
                              input logic [31:0] dst, input logic [31:0] src);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        pix_col      <= col;
        pix_row      <= row;
        dest_pixel   <= dst;
        source_pixel <= src;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // drop the request line and wait out every owed result
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic directed_mode(input mode_t mode);
        // region works out to columns 0..7, rows 3..8
        apply_settings(mode, DIRECTED_FILL, -2, 3, 10, 6, 640, 480);
        send_pixel(0, 3, DIRECTED_FILL, 32'h0000_0000);
        send_pixel(1, 3, 32'hFFFF_FFFF, 32'h1234_5678);
        send_pixel(8, 8, 32'h0000_0000, 32'hFFFF_FFFF);
        drain();
    endtask

    function automatic int pick_edge();
        case ($urandom_range(0, 5))
            0:       return -4096;
            1:       return 4095;
            2:       return 0;
            3, 4:    return int'($urandom_range(0, 128)) - 64;
            default: return int'($urandom_range(0, 8191)) - 4096;
        endcase
    endfunction

    function automatic int pick_span(input int typical);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 4096;
            2:       return 8191;
            3:       return typical;
            4, 5, 6: return int'($urandom_range(1, 300));
            default: return int'($urandom_range(0, 8191));
        endcase
    endfunction

    function automatic coord_t pick_coord(input int lo, input int hi);
        int a;
        int b;
        if (hi <= lo || $urandom_range(0, 3) == 0)
            return coord_t'($urandom());
        a = (lo - 2 < 0) ? 0 : lo - 2;
        b = (hi + 1 > COORD_MAX) ? COORD_MAX : hi + 1;
        if (a > b)
            a = b;
        return coord_t'($urandom_range(a, b));
    endfunction

    task automatic random_settings();
        mode_t       mode;
        logic [31:0] fill;
        mode = ($urandom_range(0, 9) < 8)
               ? mode_t'($urandom_range(cpro_pkg::MODE_FILL, cpro_pkg::MODE_COPY))
               : mode_t'($urandom_range(MODE_RSVD_FIRST, MODE_RSVD_LAST));
        fill = $urandom();
        case ($urandom_range(0, 3))
            0:       fill[31:24] = 8'h00;
            1:       fill[31:24] = 8'hFF;
            default: fill = fill;
        endcase
        apply_settings(mode, fill, pick_edge(), pick_edge(), pick_span(64), pick_span(48),
                       pick_span(640), pick_span(480));
    endtask

    task automatic send_random_pixel();
        int          x_hi;
        int          y_hi;
        logic [31:0] dst;
        x_hi = (cur_left + cur_cw > cur_fw) ? cur_fw : cur_left + cur_cw;
        y_hi = (cur_top + cur_ch > cur_fh) ? cur_fh : cur_top + cur_ch;
        dst  = ($urandom_range(0, 7) == 0) ? cur_fill : $urandom();
        send_pixel(pick_coord((cur_left > 0) ? cur_left : 0, x_hi),
                   pick_coord((cur_top > 0) ? cur_top : 0, y_hi), dst, $urandom());
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings leave an empty region
        send_pixel(coord_t'(COORD_MAX), coord_t'(COORD_MAX), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(0, 0, 32'h0000_0000, 32'h0000_0000);
        drain();

        directed_mode(cpro_pkg::MODE_FILL);
        directed_mode(cpro_pkg::MODE_BLEND);
        directed_mode(cpro_pkg::MODE_INVERT);
        directed_mode(cpro_pkg::MODE_CHECK);
        directed_mode(cpro_pkg::MODE_COPY);
        directed_mode(MODE_RSVD_FIRST);
        directed_mode(MODE_RSVD_FIRST + 3'd1);
        directed_mode(MODE_RSVD_LAST);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            calm = (phase % 4 == 3);
            case (phase)
                0:       apply_settings(cpro_pkg::MODE_BLEND, {8'hFF, 24'($urandom())},
                                        -4096, -4096, 8191, 8191, 4096, 4096);
                1:       apply_settings(cpro_pkg::MODE_CHECK, $urandom(), 4095, 4095,
                                        4096, 4096, 8191, 8191);
                2:       apply_settings(cpro_pkg::MODE_BLEND, {8'h00, 24'($urandom())},
                                        0, 0, 4096, 4096, 0, 0);
                default: random_settings();
            endcase
            repeat (PHASE_PIXELS) send_random_pixel();
            drain();
        end

        repeat (5) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("[clipped_pixel_raster_op_top] OK");
        else
            $display("[clipped_pixel_raster_op_top] ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/cpro_pkg.sv
rtl/cpro_region.sv
rtl/cpro_pixel_op.sv
rtl/clipped_pixel_raster_op_top.sv
test/raster_op_checker.sv
test/tb.sv
